// ===== hdl/cna_pkg.sv =====
// Shared types, codes and the saturation helper of the complex arithmetic unit.
package cna_pkg;

  localparam int unsigned DW    = 32;  // width of one fixed-point part
  localparam int unsigned QB    = 32;  // quotient bits produced by the divider
  localparam int unsigned RW    = 96;  // remainder and shifted-divisor width
  localparam int unsigned EPS_W = 17;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_EQ  = 3'd4;

  localparam logic [EPS_W-1:0] EPS_RESET = 17'd7;

  localparam logic [DW-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic          sat;
    logic [DW-1:0] val;
  } clamp_t;

  // Per-item side information that rides along with the divider.
  typedef struct packed {
    logic          is_div;
    logic          derr;
    logic          eq;
    logic          sat;
    logic          neg_re;
    logic          neg_im;
    logic          ovf_re;
    logic          ovf_im;
    logic [DW-1:0] r_re;
    logic [DW-1:0] r_im;
  } side_t;

  typedef struct packed {
    logic [RW-1:0] rem_re;
    logic [RW-1:0] rem_im;
    logic [RW-1:0] dsh;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
    side_t         side;
  } div_t;

  // Clamps a sign and magnitude pair to the 32-bit signed range.
  function automatic clamp_t clamp32(logic neg, logic [63:0] mag);
    clamp_t c;
    c.sat = 1'b0;
    if (!neg) begin
      if (mag > {32'd0, POS_MAX}) begin
        c.sat = 1'b1;
        c.val = POS_MAX;
      end else begin
        c.val = mag[DW-1:0];
      end
    end else begin
      if (mag > {32'd0, NEG_MAX}) begin
        c.sat = 1'b1;
        c.val = NEG_MAX;
      end else begin
        c.val = ~mag[DW-1:0] + 32'd1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/cna_front.sv =====
// Front pipeline: operand register, products, sums, magnitudes and divider setup.
module cna_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // a_re, a_im, b_re, b_im from the lowest bit up
  input  logic [127:0]                s_axis_tdata,
  // action
  input  logic [2:0]                  s_axis_tuser,
  input  logic [cna_pkg::EPS_W-1:0]   eps_i,
  output logic                        dv_valid_o,
  output cna_pkg::div_t               dv_data_o,
  input  logic                        dv_ready_i
);
  import cna_pkg::*;

  function automatic logic [32:0] mag33(logic [32:0] x);
    return x[32] ? (~x + 33'd1) : x;
  endfunction

  // Stage 1: operand register.
  logic              s1_v_q, s1_rdy;
  logic [2:0]        s1_act_q;
  logic signed [31:0] s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;

  // Stage 2: products and the short results.
  logic              s2_v_q, s2_rdy;
  logic [2:0]        s2_act_q;
  logic signed [63:0] s2_prr_q, s2_pii_q, s2_pir_q, s2_pri_q;
  logic [63:0]       s2_sqr_q, s2_sqi_q;
  logic [DW-1:0]     s2_rre_q, s2_rim_q;
  logic              s2_sat_q, s2_eq_q, s2_small_q;

  // Stage 3: exact sums.
  logic              s3_v_q, s3_rdy;
  logic [2:0]        s3_act_q;
  logic [64:0]       s3_sre_q, s3_sim_q;
  logic [63:0]       s3_den_q;
  logic [DW-1:0]     s3_rre_q, s3_rim_q;
  logic              s3_sat_q, s3_eq_q, s3_small_q;

  // Stage 4: sign and magnitude.
  logic              s4_v_q, s4_rdy;
  logic [2:0]        s4_act_q;
  logic              s4_nre_q, s4_nim_q;
  logic [63:0]       s4_mre_q, s4_mim_q, s4_den_q;
  logic [DW-1:0]     s4_rre_q, s4_rim_q;
  logic              s4_sat_q, s4_eq_q, s4_small_q;

  // Stage 5: divider entry.
  logic              s5_v_q, s5_rdy;
  div_t              s5_q, s5_d;

  assign s5_rdy = !s5_v_q || dv_ready_i;
  assign s4_rdy = !s4_v_q || s5_rdy;
  assign s3_rdy = !s3_v_q || s4_rdy;
  assign s2_rdy = !s2_v_q || s3_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;
  assign s_axis_tready = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= s_axis_tvalid;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
      if (s4_rdy) s4_v_q <= s3_v_q;
      if (s5_rdy) s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_act_q <= s_axis_tuser;
      s1_ar_q  <= s_axis_tdata[31:0];
      s1_ai_q  <= s_axis_tdata[63:32];
      s1_br_q  <= s_axis_tdata[95:64];
      s1_bi_q  <= s_axis_tdata[127:96];
    end
  end

  // Stage 2 logic.
  logic [32:0] sum_re, sum_im, dif_re, dif_im, ext_eps;
  logic [63:0] sqr, sqi;
  clamp_t      c2_re, c2_im;
  logic [DW-1:0] r2_re, r2_im;
  logic        sat2, eq2, small2;

  assign sum_re  = {s1_ar_q[31], s1_ar_q} + {s1_br_q[31], s1_br_q};
  assign sum_im  = {s1_ai_q[31], s1_ai_q} + {s1_bi_q[31], s1_bi_q};
  assign dif_re  = {s1_ar_q[31], s1_ar_q} - {s1_br_q[31], s1_br_q};
  assign dif_im  = {s1_ai_q[31], s1_ai_q} - {s1_bi_q[31], s1_bi_q};
  assign ext_eps = {16'd0, eps_i};
  assign sqr     = s1_br_q * s1_br_q;
  assign sqi     = s1_bi_q * s1_bi_q;

  always_comb begin
    c2_re  = '0;
    c2_im  = '0;
    r2_re  = '0;
    r2_im  = '0;
    sat2   = 1'b0;
    eq2    = 1'b0;
    small2 = ((mag33({s1_br_q[31], s1_br_q}) < ext_eps) &&
              (mag33({s1_bi_q[31], s1_bi_q}) < ext_eps)) ||
             ((s1_br_q == 32'sd0) && (s1_bi_q == 32'sd0));
    case (s1_act_q)
      ACT_ADD: begin
        c2_re = clamp32(sum_re[32], {31'd0, mag33(sum_re)});
        c2_im = clamp32(sum_im[32], {31'd0, mag33(sum_im)});
        r2_re = c2_re.val;
        r2_im = c2_im.val;
        sat2  = c2_re.sat | c2_im.sat;
      end
      ACT_SUB: begin
        c2_re = clamp32(dif_re[32], {31'd0, mag33(dif_re)});
        c2_im = clamp32(dif_im[32], {31'd0, mag33(dif_im)});
        r2_re = c2_re.val;
        r2_im = c2_im.val;
        sat2  = c2_re.sat | c2_im.sat;
      end
      ACT_EQ: begin
        eq2 = (mag33(dif_re) < ext_eps) && (mag33(dif_im) < ext_eps);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy) begin
      s2_act_q   <= s1_act_q;
      s2_prr_q   <= s1_ar_q * s1_br_q;
      s2_pii_q   <= s1_ai_q * s1_bi_q;
      s2_pir_q   <= s1_ai_q * s1_br_q;
      s2_pri_q   <= s1_ar_q * s1_bi_q;
      s2_sqr_q   <= sqr;
      s2_sqi_q   <= sqi;
      s2_rre_q   <= r2_re;
      s2_rim_q   <= r2_im;
      s2_sat_q   <= sat2;
      s2_eq_q    <= eq2;
      s2_small_q <= small2;
    end
  end

  // Stage 3 logic: the multiply and divide numerators share the four products.
  logic [64:0] xrr, xii, xir, xri;
  assign xrr = {s2_prr_q[63], s2_prr_q};
  assign xii = {s2_pii_q[63], s2_pii_q};
  assign xir = {s2_pir_q[63], s2_pir_q};
  assign xri = {s2_pri_q[63], s2_pri_q};

  always_ff @(posedge clk_i) begin
    if (s3_rdy) begin
      s3_act_q   <= s2_act_q;
      s3_sre_q   <= (s2_act_q == ACT_MUL) ? (xrr - xii) : (xrr + xii);
      s3_sim_q   <= (s2_act_q == ACT_MUL) ? (xir + xri) : (xir - xri);
      s3_den_q   <= s2_sqr_q + s2_sqi_q;
      s3_rre_q   <= s2_rre_q;
      s3_rim_q   <= s2_rim_q;
      s3_sat_q   <= s2_sat_q;
      s3_eq_q    <= s2_eq_q;
      s3_small_q <= s2_small_q;
    end
  end

  // Stage 4 logic.
  logic [64:0] mre65, mim65;
  assign mre65 = s3_sre_q[64] ? (~s3_sre_q + 65'd1) : s3_sre_q;
  assign mim65 = s3_sim_q[64] ? (~s3_sim_q + 65'd1) : s3_sim_q;

  always_ff @(posedge clk_i) begin
    if (s4_rdy) begin
      s4_act_q   <= s3_act_q;
      s4_nre_q   <= s3_sre_q[64];
      s4_nim_q   <= s3_sim_q[64];
      s4_mre_q   <= mre65[63:0];
      s4_mim_q   <= mim65[63:0];
      s4_den_q   <= s3_den_q;
      s4_rre_q   <= s3_rre_q;
      s4_rim_q   <= s3_rim_q;
      s4_sat_q   <= s3_sat_q;
      s4_eq_q    <= s3_eq_q;
      s4_small_q <= s3_small_q;
    end
  end

  // Stage 5 logic: product clamp, or numerator scaling and overflow check.
  logic [RW-1:0] num_re, num_im, den_top;
  clamp_t        c5_re, c5_im;

  assign num_re  = RW'(s4_mre_q) << FRAC_BITS;
  assign num_im  = RW'(s4_mim_q) << FRAC_BITS;
  assign den_top = {s4_den_q, 32'd0};
  assign c5_re   = clamp32(s4_nre_q, s4_mre_q >> FRAC_BITS);
  assign c5_im   = clamp32(s4_nim_q, s4_mim_q >> FRAC_BITS);

  always_comb begin
    s5_d             = '0;
    s5_d.rem_re      = num_re;
    s5_d.rem_im      = num_im;
    s5_d.dsh         = {1'b0, s4_den_q, 31'd0};
    s5_d.side.neg_re = s4_nre_q;
    s5_d.side.neg_im = s4_nim_q;
    s5_d.side.ovf_re = num_re >= den_top;
    s5_d.side.ovf_im = num_im >= den_top;
    s5_d.side.eq     = s4_eq_q;
    s5_d.side.derr   = (s4_act_q == ACT_DIV) && s4_small_q;
    s5_d.side.is_div = (s4_act_q == ACT_DIV) && !s4_small_q;
    if (s4_act_q == ACT_MUL) begin
      s5_d.side.r_re = c5_re.val;
      s5_d.side.r_im = c5_im.val;
      s5_d.side.sat  = c5_re.sat | c5_im.sat;
    end else begin
      s5_d.side.r_re = s4_rre_q;
      s5_d.side.r_im = s4_rim_q;
      s5_d.side.sat  = s4_sat_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_rdy) s5_q <= s5_d;
  end

  assign dv_valid_o = s5_v_q;
  assign dv_data_o  = s5_q;

endmodule

// ===== hdl/cna_div_step.sv =====
// One restoring-division stage that retires one quotient bit for both parts.
module cna_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cna_pkg::div_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cna_pkg::div_t out_data_o
);
  import cna_pkg::*;

  logic v_q;
  div_t data_q, data_d;
  logic ge_re, ge_im;

  assign in_ready_o = !v_q || out_ready_i;

  assign ge_re = in_data_i.rem_re >= in_data_i.dsh;
  assign ge_im = in_data_i.rem_im >= in_data_i.dsh;

  always_comb begin
    data_d        = in_data_i;
    data_d.rem_re = ge_re ? (in_data_i.rem_re - in_data_i.dsh) : in_data_i.rem_re;
    data_d.rem_im = ge_im ? (in_data_i.rem_im - in_data_i.dsh) : in_data_i.rem_im;
    data_d.q_re   = {in_data_i.q_re[QB-2:0], ge_re};
    data_d.q_im   = {in_data_i.q_im[QB-2:0], ge_im};
    data_d.dsh    = in_data_i.dsh >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) data_q <= data_d;
  end

  assign out_valid_o = v_q;
  assign out_data_o  = data_q;

endmodule

// ===== hdl/cna_divider.sv =====
// Chain of division stages, one quotient bit per stage.
module cna_divider (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cna_pkg::div_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cna_pkg::div_t out_data_o
);
  import cna_pkg::*;

  logic valid [QB+1];
  logic ready [QB+1];
  div_t data  [QB+1];

  assign valid[0]    = in_valid_i;
  assign data[0]     = in_data_i;
  assign in_ready_o  = ready[0];
  assign out_valid_o = valid[QB];
  assign out_data_o  = data[QB];
  assign ready[QB]   = out_ready_i;

  for (genvar k = 0; k < QB; k++) begin : g_step
    cna_div_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[k]),
      .in_ready_o  (ready[k]),
      .in_data_i   (data[k]),
      .out_valid_o (valid[k+1]),
      .out_ready_i (ready[k+1]),
      .out_data_o  (data[k+1])
    );
  end

endmodule

// ===== hdl/complex_number_alu.sv =====
// Throughput: one transaction per cycle while the master side takes results.
// The 32-stage quotient chain sets the depth.
// Every stage holds its own valid bit, so empty stages fill while the output is stalled.
// Reset clears all valid bits and loads epsilon with 7; data registers are not reset.
// Epsilon must be written only while the pipeline is empty.
module complex_number_alu #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // a_re, a_im, b_re, b_im from the lowest bit up
  input  logic [127:0]              s_axis_tdata,
  // action
  input  logic [2:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // r_re, r_im from the lowest bit up
  output logic [63:0]               m_axis_tdata,
  // equal, div_error, saturated from the lowest bit up
  output logic [2:0]                m_axis_tuser,
  input  logic                      eps_we_i,
  input  logic [cna_pkg::EPS_W-1:0] eps_wdata_i
);
  import cna_pkg::*;

  logic [EPS_W-1:0] eps_q;
  logic             dv_valid, dv_ready, dq_valid, dq_ready;
  div_t             dv_data, dq_data;
  logic             out_v_q;
  logic [63:0]      tdata_q, tdata_d;
  logic [2:0]       tuser_q, tuser_d;
  clamp_t           f_re, f_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (eps_we_i) begin
      eps_q <= eps_wdata_i;
    end
  end

  cna_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .eps_i         (eps_q),
    .dv_valid_o    (dv_valid),
    .dv_data_o     (dv_data),
    .dv_ready_i    (dv_ready)
  );

  cna_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dv_valid),
    .in_ready_o  (dv_ready),
    .in_data_i   (dv_data),
    .out_valid_o (dq_valid),
    .out_ready_i (dq_ready),
    .out_data_o  (dq_data)
  );

  assign dq_ready = !out_v_q || m_axis_tready;

  // A quotient that reached 2^32 has no valid low bits and is saturated outright.
  always_comb begin
    if (dq_data.side.ovf_re) begin
      f_re.sat = 1'b1;
      f_re.val = dq_data.side.neg_re ? NEG_MAX : POS_MAX;
    end else begin
      f_re = clamp32(dq_data.side.neg_re, {32'd0, dq_data.q_re});
    end
    if (dq_data.side.ovf_im) begin
      f_im.sat = 1'b1;
      f_im.val = dq_data.side.neg_im ? NEG_MAX : POS_MAX;
    end else begin
      f_im = clamp32(dq_data.side.neg_im, {32'd0, dq_data.q_im});
    end
    if (dq_data.side.is_div) begin
      tdata_d = {f_im.val, f_re.val};
      tuser_d = {f_re.sat | f_im.sat, 1'b0, 1'b0};
    end else if (dq_data.side.derr) begin
      tdata_d = '0;
      tuser_d = {1'b0, 1'b1, 1'b0};
    end else begin
      tdata_d = {dq_data.side.r_im, dq_data.side.r_re};
      tuser_d = {dq_data.side.sat, 1'b0, dq_data.side.eq};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (dq_ready) begin
      out_v_q <= dq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dq_ready) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

endmodule

// ===== test/complex_number_alu_checker.sv =====
// Checker for the complex arithmetic unit: predicts each result and compares it.
module complex_number_alu_checker
  import cna_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [127:0]        s_tdata,
  input  logic [2:0]          s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [63:0]         m_tdata,
  input  logic [2:0]          m_tuser,
  input  logic                eps_we,
  input  logic [EPS_W-1:0]    eps_wdata,
  output int                  fail_count,
  output int                  pending
);

  localparam int FB = 16;

  typedef struct packed {
    logic [31:0] r_re;
    logic [31:0] r_im;
    logic        equal;
    logic        div_error;
    logic        saturated;
  } alu_result_t;

  alu_result_t      expected_q[$];
  logic [EPS_W-1:0] eps;

  // Clamps a signed wide value to 32 bits and flags saturation.
  function automatic logic [31:0] sat32(logic signed [127:0] v, ref logic sat);
    if (v > 128'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sh8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Truncates toward zero after dropping the fraction bits.
  function automatic logic signed [127:0] shr_trunc(logic signed [127:0] v);
    logic [127:0] m;
    m = (v < 0) ? -v : v;
    m = m >> FB;
    return (v < 0) ? -$signed(m) : $signed(m);
  endfunction

  // Quotient num * 2^FB / den, truncated toward zero; integer part capped at 2^32.
  function automatic logic signed [127:0] div_trunc(logic signed [127:0] num,
                                                    logic [127:0] den);
    logic [127:0] m, q;
    m = (num < 0) ? -num : num;
    q = m / den;
    if (q > (128'd1 << 32)) q = 128'd1 << 32;
    q = (q << FB) | (((m % den) << FB) / den);
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic alu_result_t predict_alu(logic [2:0] act, logic [127:0] d);
    alu_result_t r;
    logic signed [127:0] ar, ai, br, bi, x, y, dr, di;
    logic [127:0] den;
    logic sat;
    ar = $signed(d[31:0]);
    ai = $signed(d[63:32]);
    br = $signed(d[95:64]);
    bi = $signed(d[127:96]);
    r = '0;
    sat = 1'b0;
    case (act)
      ACT_ADD, ACT_SUB, ACT_MUL: begin
        if (act == ACT_ADD) begin
          x = ar + br;
          y = ai + bi;
        end else if (act == ACT_SUB) begin
          x = ar - br;
          y = ai - bi;
        end else begin
          x = shr_trunc(ar * br - ai * bi);
          y = shr_trunc(ai * br + ar * bi);
        end
        r.r_re = sat32(x, sat);
        r.r_im = sat32(y, sat);
        r.saturated = sat;
      end
      ACT_DIV: begin
        den = br * br + bi * bi;
        dr = (br < 0) ? -br : br;
        di = (bi < 0) ? -bi : bi;
        if ((dr < eps && di < eps) || den == 0) begin
          r.div_error = 1'b1;
        end else begin
          r.r_re = sat32(div_trunc(ar * br + ai * bi, den), sat);
          r.r_im = sat32(div_trunc(ai * br - ar * bi, den), sat);
          r.saturated = sat;
        end
      end
      ACT_EQ: begin
        dr = ar - br;
        di = ai - bi;
        if (dr < 0) dr = -dr;
        if (di < 0) di = -di;
        r.equal = (dr < eps) && (di < eps);
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    alu_result_t e, got;
    if (!rst_ni) begin
      eps <= EPS_RESET;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (eps_we) eps <= eps_wdata;
      if (s_tvalid && s_tready) expected_q.push_back(predict_alu(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1], m_tuser[2]};
        if (expected_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (got.r_re !== e.r_re)
            $error("r_re: expected %h, actual %h", e.r_re, got.r_re);
          if (got.r_im !== e.r_im)
            $error("r_im: expected %h, actual %h", e.r_im, got.r_im);
          if (got.equal !== e.equal)
            $error("equal: expected %b, actual %b", e.equal, got.equal);
          if (got.div_error !== e.div_error)
            $error("div_error: expected %b, actual %b", e.div_error, got.div_error);
          if (got.saturated !== e.saturated)
            $error("saturated: expected %b, actual %b", e.saturated, got.saturated);
          if (got !== e) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

// ===== test/complex_number_alu_tb.sv =====
// Testbench top: drives the complex arithmetic unit and reports the verdict.
module complex_number_alu_tb;
  import cna_pkg::*;

  localparam int LATENCY = 38;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [127:0]       s_tdata = '0;
  logic [2:0]         s_tuser = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [63:0]        m_tdata;
  logic [2:0]         m_tuser;
  logic               eps_we = 1'b0;
  logic [EPS_W-1:0]   eps_wdata = '0;
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;
  logic               sink_hold = 1'b0;
  int                 sink_wait = 0;

  always #10 clk_i = ~clk_i;

  complex_number_alu uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser),
    .eps_we_i(eps_we), .eps_wdata_i(eps_wdata)
  );

  complex_number_alu_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .eps_we(eps_we), .eps_wdata(eps_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [31:0] pick_part();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 15);
      3: return -$urandom_range(0, 15);
      4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      5: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom();
    endcase
  endfunction

  // Sink stalls: random gaps, occasionally a long one; sometimes always ready.
  always @(negedge clk_i) begin
    int g;
    if (sink_hold) begin
      m_tready <= 1'b1;
      sink_wait <= 0;
    end else if (sink_wait > 0) begin
      m_tready <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else begin
      g = gap_len();
      m_tready <= (g == 0);
      sink_wait <= (g > 0) ? g - 1 : 0;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL complex_number_alu");
      $finish;
    end
  end

  task automatic send_op(logic [2:0] act, logic [31:0] ar, logic [31:0] ai,
                         logic [31:0] br, logic [31:0] bi);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {bi, br, ai, ar};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic set_eps(logic [EPS_W-1:0] v);
    eps_we <= 1'b1;
    eps_wdata <= v;
    @(negedge clk_i);
    eps_we <= 1'b0;
  endtask

  initial begin
    logic [EPS_W-1:0] eps_list[5];
    logic [2:0] act;
    eps_list = '{17'd7, 17'd0, 17'd65536, 17'd1, 17'd0};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, each action, small divisors, unused codes.
    send_op(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(ACT_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0);
    send_op(ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF);
    send_op(ACT_SUB, 32'h5, 32'h5, 32'h5, 32'h5);
    send_op(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_op(ACT_MUL, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0);
    send_op(ACT_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_8000, 32'h0001_0000);
    send_op(ACT_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0);
    send_op(ACT_DIV, 32'h0001_0000, 32'h0, 32'h6, 32'hFFFF_FFFA);
    send_op(ACT_DIV, 32'h0001_0000, 32'h0, 32'h7, 32'h0);
    send_op(ACT_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7, 32'h7);
    send_op(ACT_DIV, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0);
    send_op(ACT_DIV, 32'hFFFF_0000, 32'h0003_0000, 32'h0002_0000, 32'h0);
    send_op(ACT_DIV, 32'h0005_0000, 32'h0, 32'h0003_0000, 32'hFFFC_0000);
    send_op(ACT_EQ, 32'h10, 32'h10, 32'h16, 32'hA);
    send_op(ACT_EQ, 32'h10, 32'h10, 32'h17, 32'h10);
    send_op(ACT_EQ, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
    send_op(3'd5, 32'h1, 32'h2, 32'h3, 32'h4);
    send_op(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(3'd7, 32'h0, 32'h0, 32'h0, 32'h0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_eps(ph < 5 ? eps_list[ph] : EPS_W'($urandom_range(0, 65536)));
      // Directed division with a zero divisor in the phase where epsilon is zero.
      if (ph == 1) send_op(ACT_DIV, 32'h1234_5678, 32'h1, 32'h0, 32'h0);
      sink_hold <= (ph == 2);
      for (int i = 0; i < 300; i++) begin
        logic [31:0] br, bi, ar, ai;
        act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
        ar = pick_part();
        ai = pick_part();
        br = pick_part();
        bi = $urandom_range(0, 5) == 0 ? 32'h0 : pick_part();
        if (act == ACT_EQ && $urandom_range(0, 1)) begin
          br = ar + $urandom_range(0, 16) - 8;
          bi = ai + $urandom_range(0, 16) - 8;
        end
        send_op(act, ar, ai, br, bi);
      end
      drain();
    end

    if (fail_count == 0) $display("PASS complex_number_alu");
    else $display("FAIL complex_number_alu");
    $finish;
  end

endmodule
